// ----- rtl/mtim_pkg.sv -----
// mtim_pkg: types, widths and helpers for the multilevel toeplitz index map unit
// no dependencies; imported by multilevel_toeplitz_index_map_unit
package mtim_pkg;

  localparam int SIZE_W   = 7;
  localparam int FFT_W    = 23;
  localparam int IDX_W    = 18;
  localparam int DIG_W    = 6;
  localparam int ADDR_W   = 22;
  localparam int MAX_SIZE = 64;
  localparam int NSTAGES  = 10;

  // per-item operating mode carried on the input tuser
  typedef enum logic [1:0] {
    MODE_PAD   = 2'd0,
    MODE_UNPAD = 2'd1,
    MODE_ELEM  = 2'd2
  } mode_t;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_SIZE0 = 2'd0,
    REG_SIZE1 = 2'd1,
    REG_SIZE2 = 2'd2,
    REG_FFT   = 2'd3
  } reg_idx_t;

  // payload and control travelling down the pipeline
  typedef struct packed {
    logic              valid;
    logic              err;
    mode_t             mode;
    logic [IDX_W-1:0]  idx;
    logic [IDX_W-1:0]  rest;
    logic [DIG_W-1:0]  q2;
    logic [DIG_W-1:0]  q1;
    logic [SIZE_W-1:0] e0;
    logic [SIZE_W-1:0] e1;
    logic [SIZE_W-1:0] e2;
    logic [7:0]        vs1;
    logic [13:0]       g2;
    logic [15:0]       vs2;
    logic [20:0]       prod_n;
    logic [23:0]       total;
    logic [23:0]       maxpad;
    logic [23:0]       offset;
    logic [23:0]       eaddr;
    logic [23:0]       bias;
    logic [23:0]       paddr;
    logic [23:0]       uaddr;
    logic [ADDR_W-1:0] address;
  } pipe_t;

  // level stride factor 2n-1
  function automatic logic [7:0] stride_of(input logic [SIZE_W-1:0] n);
    return {n, 1'b0} - 8'd1;
  endfunction

  // one restoring division step: returns {quotient bit, new remainder}
  function automatic logic [IDX_W:0] div_step(input logic [IDX_W-1:0] rest,
                                              input logic [13:0] dvs,
                                              input logic [2:0] k);
    logic [IDX_W:0] sh;
    sh = (IDX_W+1)'(dvs) << k;
    if ({1'b0, rest} >= sh) begin
      return {1'b1, rest - sh[IDX_W-1:0]};
    end else begin
      return {1'b0, rest};
    end
  endfunction

endpackage

// ----- rtl/multilevel_toeplitz_index_map_unit.sv -----
// multilevel_toeplitz_index_map_unit: pipelined address generator for a
// three-level toeplitz generator vector; depends on mtim_pkg
//
//  channel | ports                         | transfer contents
//  --------+-------------------------------+---------------------------------------
//  in      | in_tvalid/in_tready           | tdata: linear_index, row xyz, col xyz
//          | in_tdata[55:0], in_tuser[1:0] | tuser: mode
//  out     | out_tvalid/out_tready         | tdata: address; tuser: range_error
//          | out_tdata[23:0], out_tuser[0] |
//  cfg     | cfg_valid/cfg_ready           | cfg_index selects register, cfg_data
//
// ten register stages; one item accepted per cycle while the output is not stalled
// the two digit divisions (two restoring steps per stage) set the depth
// a stalled output freezes every stage together, so nothing is lost or repeated
// synchronous active-low reset clears stage valid bits, sets the sizes to one
// and the fft length to zero
module multilevel_toeplitz_index_map_unit
  import mtim_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [17:0] linear_index, [23:18] row_x, [29:24] row_y, [35:30] row_z,
  // [41:36] col_x, [47:42] col_y, [53:48] col_z, [55:54] zero
  input  logic [55:0] in_tdata,
  // [1:0] mode
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [21:0] address, [23:22] zero
  output logic [23:0] out_tdata,
  // [0] range_error
  output logic [0:0]  out_tuser,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [22:0] cfg_data
);

  localparam int LAST = NSTAGES - 1;

  logic [SIZE_W-1:0] size0_r, size1_r, size2_r;
  logic [FFT_W-1:0]  fft_r;
  pipe_t             st_r   [NSTAGES];
  pipe_t             st_nxt [NSTAGES];
  logic              adv;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size0_r <= SIZE_W'(1);
      size1_r <= SIZE_W'(1);
      size2_r <= SIZE_W'(1);
      fft_r   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (reg_idx_t'(cfg_index))
        REG_SIZE0: size0_r <= cfg_data[SIZE_W-1:0];
        REG_SIZE1: size1_r <= cfg_data[SIZE_W-1:0];
        REG_SIZE2: size2_r <= cfg_data[SIZE_W-1:0];
        REG_FFT:   fft_r   <= cfg_data;
        default:   fft_r   <= fft_r;
      endcase
    end
  end

  // whole pipeline moves when the output register is free or taken
  assign adv       = !st_r[LAST].valid || out_tready;
  assign in_tready = adv;

  // stage logic
  always_comb begin
    logic [IDX_W:0]    r;
    logic              size_bad;
    logic              dig_bad;
    logic [DIG_W-1:0]  rx, ry, rz, cx, cy, cz;
    logic [23:0]       a;

    rx = in_tdata[23:18];
    ry = in_tdata[29:24];
    rz = in_tdata[35:30];
    cx = in_tdata[41:36];
    cy = in_tdata[47:42];
    cz = in_tdata[53:48];

    // stage 0: capture, size and digit checks, first strides
    st_nxt[0]       = '0;
    st_nxt[0].valid = in_tvalid;
    st_nxt[0].mode  = mode_t'(in_tuser);
    st_nxt[0].idx   = in_tdata[IDX_W-1:0];
    st_nxt[0].rest  = in_tdata[IDX_W-1:0];
    size_bad = (size0_r == '0) || (size0_r > SIZE_W'(MAX_SIZE)) ||
               (size1_r == '0) || (size1_r > SIZE_W'(MAX_SIZE)) ||
               (size2_r == '0) || (size2_r > SIZE_W'(MAX_SIZE));
    dig_bad  = ({1'b0, rx} >= size0_r) || ({1'b0, cx} >= size0_r) ||
               ({1'b0, ry} >= size1_r) || ({1'b0, cy} >= size1_r) ||
               ({1'b0, rz} >= size2_r) || ({1'b0, cz} >= size2_r);
    case (st_nxt[0].mode)
      MODE_PAD, MODE_UNPAD: st_nxt[0].err = size_bad;
      MODE_ELEM:            st_nxt[0].err = size_bad || dig_bad;
      default:              st_nxt[0].err = 1'b1;
    endcase
    st_nxt[0].e0  = SIZE_W'({1'b0, size0_r} + {2'b0, cx} - 8'd1 - {2'b0, rx});
    st_nxt[0].e1  = SIZE_W'({1'b0, size1_r} + {2'b0, cy} - 8'd1 - {2'b0, ry});
    st_nxt[0].e2  = SIZE_W'({1'b0, size2_r} + {2'b0, cz} - 8'd1 - {2'b0, rz});
    st_nxt[0].vs1 = stride_of(size0_r);
    st_nxt[0].g2  = 14'(size0_r) * 14'(size1_r);

    // stage 1: grid size, second stride, outer digit bits 5 and 4
    st_nxt[1]        = st_r[0];
    st_nxt[1].prod_n = 21'(st_r[0].g2) * 21'(size2_r);
    st_nxt[1].vs2    = 16'(st_r[0].vs1) * 16'(stride_of(size1_r));
    r = div_step(st_r[0].rest, st_r[0].g2, 3'd5);
    st_nxt[1].q2[5] = r[IDX_W];
    r = div_step(r[IDX_W-1:0], st_r[0].g2, 3'd4);
    st_nxt[1].q2[4] = r[IDX_W];
    st_nxt[1].rest  = r[IDX_W-1:0];

    // stage 2: index range check, total length, outer digit bits 3 and 2
    st_nxt[2]       = st_r[1];
    if ((st_r[1].mode == MODE_PAD || st_r[1].mode == MODE_UNPAD) &&
        ({3'b0, st_r[1].idx} >= st_r[1].prod_n)) begin
      st_nxt[2].err = 1'b1;
    end
    st_nxt[2].total = 24'(st_r[1].vs2) * 24'(stride_of(size2_r));
    r = div_step(st_r[1].rest, st_r[1].g2, 3'd3);
    st_nxt[2].q2[3] = r[IDX_W];
    r = div_step(r[IDX_W-1:0], st_r[1].g2, 3'd2);
    st_nxt[2].q2[2] = r[IDX_W];
    st_nxt[2].rest  = r[IDX_W-1:0];

    // stage 3: outer digit bits 1 and 0, first partial sums
    st_nxt[3] = st_r[2];
    r = div_step(st_r[2].rest, st_r[2].g2, 3'd1);
    st_nxt[3].q2[1] = r[IDX_W];
    r = div_step(r[IDX_W-1:0], st_r[2].g2, 3'd0);
    st_nxt[3].q2[0] = r[IDX_W];
    st_nxt[3].rest  = r[IDX_W-1:0];
    st_nxt[3].maxpad = 24'(size0_r - SIZE_W'(1)) +
                       24'(size1_r - SIZE_W'(1)) * 24'(st_r[2].vs1);
    st_nxt[3].eaddr  = 24'(st_r[2].e0) + 24'(st_r[2].e1) * 24'(st_r[2].vs1);

    // stage 4: finish max pad and element address, middle digit bits 5 and 4
    st_nxt[4] = st_r[3];
    st_nxt[4].maxpad = st_r[3].maxpad +
                       24'(size2_r - SIZE_W'(1)) * 24'(st_r[3].vs2);
    st_nxt[4].eaddr  = st_r[3].eaddr + 24'(st_r[3].e2) * 24'(st_r[3].vs2);
    r = div_step(st_r[3].rest, 14'(size0_r), 3'd5);
    st_nxt[4].q1[5] = r[IDX_W];
    r = div_step(r[IDX_W-1:0], 14'(size0_r), 3'd4);
    st_nxt[4].q1[4] = r[IDX_W];
    st_nxt[4].rest  = r[IDX_W-1:0];

    // stage 5: unpad offset, middle digit bits 3 and 2
    st_nxt[5] = st_r[4];
    st_nxt[5].offset = st_r[4].total - st_r[4].maxpad;
    r = div_step(st_r[4].rest, 14'(size0_r), 3'd3);
    st_nxt[5].q1[3] = r[IDX_W];
    r = div_step(r[IDX_W-1:0], 14'(size0_r), 3'd2);
    st_nxt[5].q1[2] = r[IDX_W];
    st_nxt[5].rest  = r[IDX_W-1:0];

    // stage 6: middle digit bits 1 and 0, bias and short fft check
    st_nxt[6] = st_r[5];
    r = div_step(st_r[5].rest, 14'(size0_r), 3'd1);
    st_nxt[6].q1[1] = r[IDX_W];
    r = div_step(r[IDX_W-1:0], 14'(size0_r), 3'd0);
    st_nxt[6].q1[0] = r[IDX_W];
    st_nxt[6].rest  = r[IDX_W-1:0];
    st_nxt[6].bias  = 24'(fft_r) - st_r[5].offset;
    if (st_r[5].mode == MODE_UNPAD && 24'(fft_r) < st_r[5].offset) begin
      st_nxt[6].err = 1'b1;
    end

    // stage 7: pad address from the three digits
    st_nxt[7] = st_r[6];
    st_nxt[7].paddr = 24'(st_r[6].rest) +
                      24'(st_r[6].q1) * 24'(st_r[6].vs1) +
                      24'(st_r[6].q2) * 24'(st_r[6].vs2);

    // stage 8: unpad address
    st_nxt[8] = st_r[7];
    st_nxt[8].uaddr = st_r[7].paddr + st_r[7].bias;

    // stage 9: select by mode, final range checks
    st_nxt[9] = st_r[8];
    case (st_r[8].mode)
      MODE_PAD:  a = st_r[8].paddr;
      MODE_ELEM: a = st_r[8].eaddr;
      MODE_UNPAD: begin
        a = st_r[8].uaddr;
        if (st_r[8].uaddr >= 24'(fft_r)) begin
          st_nxt[9].err = 1'b1;
        end
      end
      default: begin
        a = '0;
        st_nxt[9].err = 1'b1;
      end
    endcase
    if (a[23:ADDR_W] != '0) begin
      st_nxt[9].err = 1'b1;
    end
    st_nxt[9].address = st_nxt[9].err ? '0 : a[ADDR_W-1:0];
  end

  // stage registers, valid bits only are reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NSTAGES; k++) begin
        st_r[k].valid <= 1'b0;
      end
    end else if (adv) begin
      for (int k = 0; k < NSTAGES; k++) begin
        st_r[k] <= st_nxt[k];
      end
    end
  end

  // result channel
  assign out_tvalid   = st_r[LAST].valid;
  assign out_tdata    = {2'b00, st_r[LAST].address};
  assign out_tuser[0] = st_r[LAST].err;

  // checks
  a_ready_follows_output: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!out_tvalid || out_tready))
    else $error("input ready does not follow the output stage");

  a_accept_enters_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> st_r[0].valid)
    else $error("accepted transfer missing from first stage");

  a_stall_holds_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> $stable(st_r[LAST - 1].valid))
    else $error("pipeline moved during output stall");

  a_error_zero_address: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r[LAST - 1].valid && adv && st_nxt[LAST].err) |=> (out_tdata == '0))
    else $error("flagged result carries a non-zero address");

  a_cfg_size0_written: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_valid && cfg_ready && cfg_index == REG_SIZE0) |=>
    (size0_r == $past(cfg_data[SIZE_W-1:0])))
    else $error("size register for level zero not updated");

endmodule
